// ===== rtl/address_range_match_table_core_macros.svh =====
// Assertion macros used by the range table core RTL.
`ifndef ADDRESS_RANGE_MATCH_TABLE_CORE_MACROS_SVH
`define ADDRESS_RANGE_MATCH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ARMT_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ARMT_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/armt_pkg.sv =====
package armt_pkg;

    localparam int ARMT_ENTRIES = 16;
    localparam int ADDR_W       = 64;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_OVERLAP = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } state_t;

    // Command word as seen by every cell while a sweep runs.
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] rng_start;
        logic [ADDR_W-1:0] rng_end;
        logic [ADDR_W-1:0] benefit;
    } bcast_t;

    // Running result handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              overlap;
        logic              free_found;
        logic [ADDR_W-1:0] benefit;
        logic [ADDR_W-1:0] rng_start;
        logic [ADDR_W-1:0] rng_end;
    } acc_t;

    typedef struct packed {
        logic ins;
        logic clr;
    } commit_t;

endpackage

// ===== rtl/armt_cell.sv =====
module armt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  armt_pkg::bcast_t bc,
    input  armt_pkg::acc_t   acc_in,
    input  armt_pkg::commit_t commit,
    output armt_pkg::acc_t   acc_out
);
    import armt_pkg::*;

    logic              valid_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [ADDR_W-1:0] benefit_reg;
    logic              first_free_reg;
    acc_t              acc_reg;
    acc_t              acc_next;
    logic              match;
    logic              ovl;
    logic              take_slot;

    assign match = valid_reg && (start_reg <= bc.addr) && (bc.addr < end_reg);
    assign ovl   = valid_reg &&
                   (((bc.rng_start <= start_reg) && (start_reg < bc.rng_end)) ||
                    ((start_reg <= bc.rng_start) && (bc.rng_start < end_reg)));

    always_comb
    begin
        acc_next = acc_in;
        if (acc_in.valid)
        begin
            // keep the lowest matching entry
            if ((bc.cmd == CMD_LOOKUP) && match && !acc_in.hit)
            begin
                acc_next.hit       = 1'b1;
                acc_next.benefit   = benefit_reg;
                acc_next.rng_start = start_reg;
                acc_next.rng_end   = end_reg;
            end
            acc_next.overlap    = acc_in.overlap | ovl;
            acc_next.free_found = acc_in.free_found | !valid_reg;
        end
    end

    assign take_slot = commit.ins && first_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            valid_reg      <= 1'b0;
            first_free_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (acc_in.valid)
                first_free_reg <= !valid_reg && !acc_in.free_found;
            if (commit.clr)
                valid_reg <= 1'b0;
            else if (take_slot)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_slot)
        begin
            start_reg   <= bc.rng_start;
            end_reg     <= bc.rng_end;
            benefit_reg <= bc.benefit;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ===== rtl/address_range_match_table_core.sv =====
// Channel | Handshake           | Word
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_stall | command, lookup_address, range_start/end/benefit
// out     | out_valid/out_stall | status, hit, found_benefit/start/end
//
// A token walks the cell chain one cell per cycle, then the result is loaded into
// the output register and out_valid rises.
// Take a new word only when the chain is idle and the output register is empty,
// so one word's result has left the block before the next word is taken.
// rst_n clears all valid bits, so the table starts empty; no clearing pass.
// A stalled result holds in the output register until taken.
module address_range_match_table_core #(
    parameter int TABLE_ENTRIES = armt_pkg::ARMT_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [63:0] lookup_address,
    input  logic [63:0] range_start,
    input  logic [63:0] range_end,
    input  logic [63:0] range_benefit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        hit,
    output logic [63:0] found_benefit,
    output logic [63:0] found_start,
    output logic [63:0] found_end
);
    import armt_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    bcast_t            bc_reg;
    logic              empty_reg;
    logic              start_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic              hit_reg;
    logic [ADDR_W-1:0] benefit_reg;
    logic [ADDR_W-1:0] fstart_reg;
    logic [ADDR_W-1:0] fend_reg;
    logic              accept;
    logic              done;
    commit_t           commit;
    acc_t              chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] token_vec;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    // inject the token into cell 0 with an empty result
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            armt_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .bc     (bc_reg),
                .acc_in (chain[g]),
                .commit (commit),
                .acc_out(chain[g+1])
            );
            assign token_vec[g] = chain[g+1].valid;
        end
    endgenerate

    assign done = chain[TABLE_ENTRIES].valid;

    always_comb
    begin
        status_next = STAT_OK;
        if (bc_reg.cmd == CMD_INSERT)
        begin
            priority if (empty_reg)
                status_next = STAT_EMPTY;
            else if (chain[TABLE_ENTRIES].overlap)
                status_next = STAT_OVERLAP;
            else if (!chain[TABLE_ENTRIES].free_found)
                status_next = STAT_FULL;
            else
                status_next = STAT_OK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        commit.ins = 1'b0;
        commit.clr = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                    commit.ins = (bc_reg.cmd == CMD_INSERT) && (status_next == STAT_OK);
                    commit.clr = (bc_reg.cmd == CMD_CLEAR);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bc_reg.cmd       <= cmd_t'(command);
            bc_reg.addr      <= lookup_address;
            bc_reg.rng_start <= range_start;
            bc_reg.rng_end   <= range_end;
            bc_reg.benefit   <= range_benefit;
            empty_reg        <= (range_end <= range_start);
        end
        if (done)
        begin
            status_reg  <= status_next;
            hit_reg     <= chain[TABLE_ENTRIES].hit;
            benefit_reg <= chain[TABLE_ENTRIES].benefit;
            fstart_reg  <= chain[TABLE_ENTRIES].rng_start;
            fend_reg    <= chain[TABLE_ENTRIES].rng_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign found_benefit = benefit_reg;
    assign found_start   = fstart_reg;
    assign found_end     = fend_reg;

`include "address_range_match_table_core_macros.svh"

    `ARMT_ASSERT_NOW(a_no_overwrite, clk, rst_n, done, !out_valid_reg, "result would overwrite a pending word")
    `ARMT_ASSERT_NEXT(a_accept_sweeps, clk, rst_n, accept, state_reg == S_SWEEP, "accepted word did not start a sweep")
    `ARMT_ASSERT_NOW(a_single_token, clk, rst_n, 1'b1, $onehot0(token_vec), "more than one token in the cell chain")
    `ARMT_ASSERT_NOW(a_hit_ok, clk, rst_n, out_valid_reg && hit_reg, status_reg == STAT_OK, "hit reported with a reject status")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import armt_pkg::*;

    localparam int SLOTS = ARMT_ENTRIES;
    localparam int TAIL_CYCLES = 3 * (SLOTS + 2);
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct {
        status_t     status;
        logic        hit;
        logic [63:0] benefit;
        logic [63:0] lo;
        logic [63:0] hi;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_LOOKUP;
    logic [63:0] lookup_address = '0;
    logic [63:0] range_start = '0;
    logic [63:0] range_end = '0;
    logic [63:0] range_benefit = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_benefit;
    logic [63:0] found_start;
    logic [63:0] found_end;

    // Shadow copy of the range table
    bit          slot_used    [SLOTS];
    logic [63:0] slot_lo      [SLOTS];
    logic [63:0] slot_hi      [SLOTS];
    logic [63:0] slot_benefit [SLOTS];

    table_reply_t table_responses [$];
    table_reply_t oldest_reply;
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          stall_hold_cycles = 0;
    logic [63:0] window_base = 64'h0000_0000_0010_0000;

    always #4 clk = ~clk;

    address_range_match_table_core #(
        .TABLE_ENTRIES(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .lookup_address(lookup_address),
        .range_start(range_start),
        .range_end(range_end),
        .range_benefit(range_benefit),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .hit(hit),
        .found_benefit(found_benefit),
        .found_start(found_start),
        .found_end(found_end)
    );

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic table_reply_t apply_table_command(input cmd_t op,
                                                         input logic [63:0] addr,
                                                         input logic [63:0] lo,
                                                         input logic [63:0] hi,
                                                         input logic [63:0] benefit);
        table_reply_t r;
        int free_slot;
        bit matched;
        bit clash;
        r = '{STAT_OK, 1'b0, '0, '0, '0};
        free_slot = -1;
        matched = 1'b0;
        clash = 1'b0;
        case (op)
            CMD_LOOKUP:
            begin
                // Lowest matching slot wins
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!matched && slot_used[i] && slot_lo[i] <= addr && addr < slot_hi[i])
                    begin
                        matched = 1'b1;
                        r.hit = 1'b1;
                        r.benefit = slot_benefit[i];
                        r.lo = slot_lo[i];
                        r.hi = slot_hi[i];
                    end
                end
            end
            CMD_INSERT:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i])
                    begin
                        if ((lo <= slot_lo[i] && slot_lo[i] < hi) ||
                            (slot_lo[i] <= lo && lo < slot_hi[i]))
                            clash = 1'b1;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                // Empty beats overlap beats full
                if (hi <= lo)
                    r.status = STAT_EMPTY;
                else if (clash)
                    r.status = STAT_OVERLAP;
                else if (free_slot < 0)
                    r.status = STAT_FULL;
                else
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_lo[free_slot] = lo;
                    slot_hi[free_slot] = hi;
                    slot_benefit[free_slot] = benefit;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_used[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Aim lookups at the edges and the inside of stored ranges, or anywhere in the window if the slot is free
    function automatic logic [63:0] probe_address();
        int s;
        s = $urandom_range(SLOTS - 1);
        if (!slot_used[s])
            return window_base + $urandom_range(4095);
        case ($urandom_range(4))
            0: return slot_lo[s];
            1: return slot_hi[s] - 64'd1;
            2: return slot_hi[s];
            3: return slot_lo[s] - 64'd1;
            default: return slot_lo[s] + (rnd64() % (slot_hi[s] - slot_lo[s]));
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic issue_word(input cmd_t op, input logic [63:0] addr,
                              input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] benefit);
        table_reply_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= op;
        lookup_address <= addr;
        range_start <= lo;
        range_end <= hi;
        range_benefit <= benefit;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_table_command(op, addr, lo, hi, benefit);
        table_responses.push_back(r);
        @(negedge clk);
    endtask

    task automatic await_all_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (table_responses.size() != 0);
    endtask

    task automatic random_word();
        int pick;
        logic [63:0] lo;
        logic [63:0] hi;
        pick = $urandom_range(99);
        if (pick < 2)
        begin
            // Clear the table and move to a fresh address window, sometimes at the top of the space
            window_base = ($urandom_range(3) == 0) ? ALL_ONES - 64'd4095 : rnd64();
            issue_word(CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
        end
        else if (pick < 5)
        begin
            issue_word(cmd_t'($urandom_range(3)), rnd64(), rnd64(), rnd64(), rnd64());
        end
        else if (pick < 52)
        begin
            lo = window_base + $urandom_range(4095);
            case ($urandom_range(19))
                0: hi = lo;
                1: hi = lo - $urandom_range(1, 64);
                2: hi = rnd64();
                default: hi = lo + $urandom_range(1, 256);
            endcase
            issue_word(CMD_INSERT, rnd64(), lo, hi, rnd64());
        end
        else
        begin
            issue_word(CMD_LOOKUP, probe_address(), rnd64(), rnd64(), rnd64());
        end
    endtask

    task automatic test_basic_commands();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        issue_word(CMD_LOOKUP, '0, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, ALL_ONES, rnd64(), rnd64(), rnd64());
        issue_word(CMD_INSERT, rnd64(), 64'h1000, 64'h2000, ALL_ONES);
        issue_word(CMD_INSERT, rnd64(), 64'h2000, 64'h2000, rnd64());
        issue_word(CMD_INSERT, rnd64(), ALL_ONES, '0, rnd64());
        issue_word(CMD_INSERT, rnd64(), 64'h1800, 64'h2800, rnd64());
        issue_word(CMD_INSERT, rnd64(), 64'h0800, 64'h1001, rnd64());
        issue_word(CMD_INSERT, rnd64(), 64'h1000, 64'h2000, rnd64());
        // Half-open ranges: touching neighbors do not overlap
        issue_word(CMD_INSERT, rnd64(), 64'h0800, 64'h1000, 64'h1234_5678_9abc_def0);
        issue_word(CMD_INSERT, rnd64(), 64'h2000, 64'h3000, '0);
        issue_word(CMD_LOOKUP, 64'h1000, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, 64'h1fff, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, 64'h2000, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, 64'h3000, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, 64'h07ff, rnd64(), rnd64(), rnd64());
        issue_word(CMD_INSERT, rnd64(), 64'hffff_ffff_ffff_0000, ALL_ONES,
                   64'h5555_5555_5555_5555);
        issue_word(CMD_LOOKUP, ALL_ONES, rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, ALL_ONES - 64'd1, rnd64(), rnd64(), rnd64());
        issue_word(CMD_INSERT, rnd64(), '0, ALL_ONES, rnd64());
        issue_word(CMD_NOP, rnd64(), rnd64(), rnd64(), rnd64());
        issue_word(CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
        issue_word(CMD_LOOKUP, 64'h1000, rnd64(), rnd64(), rnd64());
        issue_word(CMD_INSERT, rnd64(), '0, ALL_ONES, 64'haaaa_aaaa_aaaa_aaaa);
        issue_word(CMD_LOOKUP, 64'hdead_beef_0bad_f00d, rnd64(), rnd64(), rnd64());
        issue_word(CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
        await_all_results();
    endtask

    task automatic test_table_full();
        logic [63:0] base;
        base = rnd64();
        base[63] = 1'b0;
        issue_word(CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
        for (int i = 0; i < SLOTS; i++)
            issue_word(CMD_INSERT, rnd64(), base + i * 64'h100,
                       base + i * 64'h100 + 64'h80, rnd64());
        issue_word(CMD_INSERT, rnd64(), base + 64'h80, base + 64'h100, rnd64());
        // Overlap and empty are reported ahead of full
        issue_word(CMD_INSERT, rnd64(), base + 64'h40, base + 64'h90, rnd64());
        issue_word(CMD_INSERT, rnd64(), base + 64'h90, base + 64'h90, rnd64());
        issue_word(CMD_LOOKUP, base + (SLOTS - 1) * 64'h100 + 64'h7f, rnd64(), rnd64(),
                   rnd64());
        issue_word(CMD_LOOKUP, base + 64'h80, rnd64(), rnd64(), rnd64());
        await_all_results();
    endtask

    task automatic test_output_hold();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(posedge clk);
        stall_hold_cycles = 300;
        @(negedge clk);
        repeat (30)
            random_word();
        await_all_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int words);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (words)
            random_word();
        await_all_results();
    endtask

    always @(negedge clk)
    begin
        if (stall_hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            stall_hold_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (table_responses.size() == 0)
            begin
                $error("result word with no command pending");
                error_count++;
            end
            else
            begin
                oldest_reply = table_responses.pop_front();
                compare_field("status", oldest_reply.status, status);
                compare_field("hit", oldest_reply.hit, hit);
                compare_field("found_benefit", oldest_reply.benefit, found_benefit);
                compare_field("found_start", oldest_reply.lo, found_start);
                compare_field("found_end", oldest_reply.hi, found_end);
            end
        end
    end

    initial
    begin
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_commands();
        test_table_full();
        test_output_hold();
        test_random_traffic(0, 0, 240);
        test_random_traffic(47, 0, 240);
        test_random_traffic(0, 47, 240);
        test_random_traffic(13, 13, 240);
        // Catch stray result words after the last expected one
        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== address_range_match_table_core.f =====
+incdir+rtl
rtl/armt_pkg.sv
rtl/armt_cell.sv
rtl/address_range_match_table_core.sv
tb/sv/tb_top.sv
